// ===== rtl/sdspi_pkg.sv =====
// Package for the SD card SPI-mode bring-up sequencer.
// Holds phase and command codes, register indexes and reset constants; no dependencies.
`timescale 1ns / 1ps
package sdspi_pkg;

   typedef enum logic [3:0] {
      PH_IDLE, PH_WAIT_TICK, PH_DUMMY, PH_POLL, PH_FRAME, PH_RESP, PH_R7, PH_OCR,
      PH_REL_FAIL, PH_REL_INIT_OK, PH_REL_DOWN_OK, PH_DOWN_POLL
   } phase_type;

   typedef enum logic [1:0] {
      OP_START = 2'd0, OP_BYTE = 2'd1, OP_TICK = 2'd2, OP_SHUTDOWN = 2'd3
   } op_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_IO_ERR  = 2'd1;
   localparam logic [1:0] ST_NO_CARD = 2'd2;

   localparam logic [1:0] REG_INIT_TIMEOUT  = 2'd0;
   localparam logic [1:0] REG_READY_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_RESP_POLLS    = 2'd2;
   localparam logic [1:0] REG_BLOCK_LENGTH  = 2'd3;

   localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
   localparam logic [5:0] CMD_IF_COND  = 6'd8;
   localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
   localparam logic [5:0] CMD_OP_COND  = 6'd41;
   localparam logic [5:0] CMD_APP      = 6'd55;
   localparam logic [5:0] CMD_READ_OCR = 6'd58;

   localparam int unsigned DUMMY_BYTES_DEF = 10;

   localparam logic [10:0] INIT_TIMEOUT_RST  = 11'd1200;
   localparam logic [9:0]  READY_TIMEOUT_RST = 10'd1000;
   localparam logic [3:0]  RESP_POLLS_RST    = 4'd8;
   localparam logic [11:0] BLOCK_LENGTH_RST  = 12'd512;

   localparam logic [7:0] IDLE_BYTE = 8'hFF;

   typedef struct packed {
      logic [10:0] init_timeout_ms;
      logic [9:0]  ready_timeout_ms;
      logic [3:0]  response_polls;
      logic [11:0] block_length;
   } cfg_type;

endpackage

// ===== rtl/sdspi_frame.sv =====
// Command frame byte generator: command byte, 32-bit argument, CRC byte.
// Depends on sdspi_pkg.
`timescale 1ns / 1ps
module sdspi_frame (
   input  logic [5:0]  cmd_index,
   input  logic [3:0]  byte_index,
   input  logic        version_one,
   input  logic [11:0] block_length,
   output logic [7:0]  frame_byte
);
   import sdspi_pkg::*;

   logic [31:0] arg;

   always_comb begin
      arg = 32'd0;
      if (cmd_index == CMD_IF_COND) begin
         arg = 32'h0000_01AA;
      end else if (cmd_index == CMD_OP_COND) begin
         arg = version_one ? 32'd0 : 32'h4000_0000;
      end else if (cmd_index == CMD_BLOCKLEN) begin
         arg = {20'd0, block_length};
      end
   end

   always_comb begin
      case (byte_index)
         4'd0: frame_byte = {2'b01, cmd_index};
         4'd1: frame_byte = arg[31:24];
         4'd2: frame_byte = arg[23:16];
         4'd3: frame_byte = arg[15:8];
         4'd4: frame_byte = arg[7:0];
         default: begin
            if (cmd_index == CMD_GO_IDLE) frame_byte = 8'h95;
            else if (cmd_index == CMD_IF_COND) frame_byte = 8'h87;
            else frame_byte = 8'h01;
         end
      endcase
   end
endmodule

// ===== rtl/sd_card_spi_init_sequencer_core.sv =====
// Top level of the SD card SPI-mode bring-up sequencer.
// Depends on sdspi_pkg and sdspi_frame.
//
//  channel | direction | handshake              | payload
//  req_    | in        | req_valid / req_ready  | command, rx_byte, card_absent
//  rsp_    | out       | rsp_valid / rsp_ready  | tx byte, chip select, done, status, flags
//  csr_    | in        | csr_valid / csr_ready  | index (2 bit), data (12 bit)
//
// Each request is registered and then decided by the phase logic; its result (if
// any) lands in a one-deep output register; one request per cycle when not stalled.
// req_ready drops only while the held request must write a result and the result
// register is still full and not being taken.
// Synchronous active-high reset returns to idle with the register defaults.
// A full result register stalls the pipeline only when a new result must be written.
`timescale 1ns / 1ps
module sd_card_spi_init_sequencer_core #(
   parameter int unsigned DUMMY_BYTES = sdspi_pkg::DUMMY_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_card_absent,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_chip_select_high,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic        rsp_high_capacity,
   output logic        rsp_legacy_card,
   output logic        rsp_card_ready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);
   import sdspi_pkg::*;

   localparam logic [3:0] DUMMY_N = 4'(DUMMY_BYTES);

   // configuration
   cfg_type cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{INIT_TIMEOUT_RST, READY_TIMEOUT_RST, RESP_POLLS_RST, BLOCK_LENGTH_RST};
      end else if (csr_valid) begin
         case (csr_index)
            REG_INIT_TIMEOUT:  cfg_ff.init_timeout_ms  <= csr_data[10:0];
            REG_READY_TIMEOUT: cfg_ff.ready_timeout_ms <= csr_data[9:0];
            REG_RESP_POLLS:    cfg_ff.response_polls   <= csr_data[3:0];
            REG_BLOCK_LENGTH:  cfg_ff.block_length     <= csr_data;
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // input stage (holds the request when the decision stage is stalled)
   logic        in_vld_ff;
   logic [1:0]  in_cmd_ff;
   logic [7:0]  in_rx_ff;
   logic        in_abs_ff;
   logic        stall;
   logic        emit;

   assign req_ready = !in_vld_ff || !stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_cmd_ff <= req_command;
         in_rx_ff  <= req_rx_byte;
         in_abs_ff <= req_card_absent;
      end
   end

   // sequencer state
   phase_type   phase_ff, phase_in;
   logic [3:0]  bcnt_ff, bcnt_in, pcnt_ff, pcnt_in;
   logic [10:0] loop_ff, loop_in;
   logic [9:0]  busy_ff, busy_in;
   logic [5:0]  cidx_ff, cidx_in;
   logic [7:0]  lresp_ff, lresp_in;
   logic        cap_ff, cap_in, v1_ff, v1_in, rdy_ff, rdy_in;

   // result
   logic        o_tx, o_cs, o_done;
   logic [7:0]  o_byte;
   logic [1:0]  o_st;

   logic [7:0]  fbyte;
   logic [3:0]  fidx;
   logic [3:0]  bnext;
   logic [3:0]  pnext;
   logic [7:0]  r1;
   logic        r1_go;
   logic [7:0]  ocr;

   assign bnext = bcnt_ff + 4'd1;
   assign pnext = pcnt_ff + 4'd1;
   assign fidx  = (phase_ff == PH_POLL) ? 4'd0 : bnext;

   sdspi_frame u_frame (
      .cmd_index   (cidx_ff),
      .byte_index  (fidx),
      .version_one (v1_ff),
      .block_length(cfg_ff.block_length),
      .frame_byte  (fbyte)
   );

   always_comb begin
      phase_in = phase_ff; bcnt_in = bcnt_ff; pcnt_in = pcnt_ff;
      loop_in = loop_ff; busy_in = busy_ff; cidx_in = cidx_ff;
      lresp_in = lresp_ff; cap_in = cap_ff; v1_in = v1_ff; rdy_in = rdy_ff;
      emit = 1'b0; o_tx = 1'b0; o_byte = 8'd0; o_cs = 1'b1; o_done = 1'b0; o_st = ST_OK;
      r1 = 8'hFF; r1_go = 1'b0; ocr = lresp_ff;

      if (in_vld_ff) begin
         case (op_type'(in_cmd_ff))
            OP_START: begin
               rdy_in = 1'b0; v1_in = 1'b0; cap_in = 1'b0;
               lresp_in = 8'hFF; bcnt_in = 4'd0; pcnt_in = 4'd0;
               if (in_abs_ff) begin
                  phase_in = PH_IDLE; emit = 1'b1; o_done = 1'b1; o_st = ST_NO_CARD;
               end else begin
                  phase_in = PH_WAIT_TICK;
               end
            end
            OP_TICK: begin
               if (busy_ff != 10'h3FF) busy_in = busy_ff + 10'd1;
               if (loop_ff != 11'h7FF) loop_in = loop_ff + 11'd1;
               if (phase_ff == PH_WAIT_TICK) begin
                  phase_in = PH_DUMMY; bcnt_in = 4'd0;
                  emit = 1'b1; o_tx = 1'b1; o_byte = IDLE_BYTE; o_cs = 1'b1;
               end
            end
            OP_SHUTDOWN: begin
               if (rdy_ff) begin
                  phase_in = PH_DOWN_POLL; busy_in = 10'd0;
                  emit = 1'b1; o_tx = 1'b1; o_byte = IDLE_BYTE; o_cs = 1'b0;
               end else begin
                  v1_in = 1'b0; cap_in = 1'b0;
                  phase_in = PH_IDLE; emit = 1'b1; o_done = 1'b1;
               end
            end
            default: begin
               emit = 1'b1; o_tx = 1'b1; o_byte = IDLE_BYTE; o_cs = 1'b0;
               case (phase_ff)
                  PH_DUMMY: begin
                     bcnt_in = bnext;
                     if (bnext < DUMMY_N) begin
                        o_cs = 1'b1;
                     end else begin
                        cidx_in = CMD_GO_IDLE; busy_in = 10'd0; phase_in = PH_POLL;
                     end
                  end
                  PH_POLL: begin
                     if (in_rx_ff == 8'hFF) begin
                        phase_in = PH_FRAME; bcnt_in = 4'd0; o_byte = fbyte;
                     end else if (busy_ff >= cfg_ff.ready_timeout_ms) begin
                        r1_go = 1'b1;
                     end
                  end
                  PH_FRAME: begin
                     bcnt_in = bnext;
                     if (bnext < 4'd6) begin
                        o_byte = fbyte;
                     end else begin
                        phase_in = PH_RESP; pcnt_in = 4'd0;
                     end
                  end
                  PH_RESP: begin
                     if (!in_rx_ff[7]) begin
                        r1 = in_rx_ff; r1_go = 1'b1;
                     end else begin
                        pcnt_in = pnext;
                        if (pnext >= cfg_ff.response_polls) r1_go = 1'b1;
                     end
                  end
                  PH_R7: begin
                     if (bcnt_ff == 4'd2 && in_rx_ff[3:0] != 4'h1) begin
                        phase_in = PH_REL_FAIL; o_cs = 1'b1;
                     end else if (bcnt_ff >= 4'd3) begin
                        if (in_rx_ff != 8'hAA) begin
                           phase_in = PH_REL_FAIL; o_cs = 1'b1;
                        end else begin
                           loop_in = 11'd0; cidx_in = CMD_APP; busy_in = 10'd0;
                           phase_in = PH_POLL;
                        end
                     end else begin
                        bcnt_in = bnext;
                     end
                  end
                  PH_OCR: begin
                     if (bcnt_ff == 4'd0) begin
                        lresp_in = in_rx_ff; ocr = in_rx_ff;
                     end
                     if (bcnt_ff < 4'd3) begin
                        bcnt_in = bnext;
                     end else if (!ocr[7]) begin
                        phase_in = PH_REL_FAIL; o_cs = 1'b1;
                     end else begin
                        if (ocr[6] && !v1_ff) cap_in = 1'b1;
                        if (!(cap_ff || (ocr[6] && !v1_ff))) begin
                           cidx_in = CMD_BLOCKLEN; busy_in = 10'd0; phase_in = PH_POLL;
                        end else begin
                           phase_in = PH_REL_INIT_OK; o_cs = 1'b1;
                        end
                     end
                  end
                  PH_DOWN_POLL: begin
                     if (in_rx_ff == 8'hFF) begin
                        phase_in = PH_REL_DOWN_OK; o_cs = 1'b1;
                     end else if (busy_ff >= cfg_ff.ready_timeout_ms) begin
                        phase_in = PH_REL_FAIL; o_cs = 1'b1;
                     end
                  end
                  PH_REL_FAIL: begin
                     phase_in = PH_IDLE; o_tx = 1'b0; o_byte = 8'd0; o_cs = 1'b1;
                     o_done = 1'b1; o_st = ST_IO_ERR;
                  end
                  PH_REL_INIT_OK: begin
                     rdy_in = 1'b1;
                     phase_in = PH_IDLE; o_tx = 1'b0; o_byte = 8'd0; o_cs = 1'b1;
                     o_done = 1'b1;
                  end
                  PH_REL_DOWN_OK: begin
                     rdy_in = 1'b0; v1_in = 1'b0; cap_in = 1'b0;
                     phase_in = PH_IDLE; o_tx = 1'b0; o_byte = 8'd0; o_cs = 1'b1;
                     o_done = 1'b1;
                  end
                  default: emit = 1'b0;
               endcase

               // command completion on R1
               if (r1_go) begin
                  lresp_in = r1;
                  o_cs = 1'b0;
                  case (cidx_ff)
                     CMD_GO_IDLE: begin
                        if (r1 == 8'h01) begin
                           cidx_in = CMD_IF_COND; busy_in = 10'd0; phase_in = PH_POLL;
                        end else begin
                           phase_in = PH_REL_FAIL; o_cs = 1'b1;
                        end
                     end
                     CMD_IF_COND: begin
                        if (r1 == 8'h01) begin
                           phase_in = PH_R7; bcnt_in = 4'd0;
                        end else if (r1 == 8'h05) begin
                           v1_in = 1'b1; loop_in = 11'd0; cidx_in = CMD_APP;
                           busy_in = 10'd0; phase_in = PH_POLL;
                        end else begin
                           phase_in = PH_REL_FAIL; o_cs = 1'b1;
                        end
                     end
                     CMD_APP: begin
                        if (r1 > 8'h01) begin
                           phase_in = PH_REL_FAIL; o_cs = 1'b1;
                        end else begin
                           cidx_in = CMD_OP_COND; busy_in = 10'd0; phase_in = PH_POLL;
                        end
                     end
                     CMD_OP_COND: begin
                        if (r1 == 8'h01 && loop_ff < cfg_ff.init_timeout_ms) begin
                           cidx_in = CMD_APP; busy_in = 10'd0; phase_in = PH_POLL;
                        end else if (r1 == 8'h00) begin
                           cidx_in = CMD_READ_OCR; busy_in = 10'd0; phase_in = PH_POLL;
                        end else begin
                           phase_in = PH_REL_FAIL; o_cs = 1'b1;
                        end
                     end
                     CMD_READ_OCR: begin
                        if (r1 != 8'h00) begin
                           phase_in = PH_REL_FAIL; o_cs = 1'b1;
                        end else begin
                           phase_in = PH_OCR; bcnt_in = 4'd0;
                        end
                     end
                     CMD_BLOCKLEN: begin
                        phase_in = (r1 != 8'h00) ? PH_REL_FAIL : PH_REL_INIT_OK;
                        o_cs = 1'b1;
                     end
                     default: begin
                        phase_in = PH_REL_FAIL; o_cs = 1'b1;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   // result register: hold a result until taken, stall only if a new one must land
   logic       ov_ff;
   assign stall = ov_ff && !rsp_ready && emit;
   logic       adv;
   assign adv = in_vld_ff && !stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; bcnt_ff <= 4'd0; pcnt_ff <= 4'd0;
         loop_ff <= 11'd0; busy_ff <= 10'd0; cidx_ff <= 6'd0;
         lresp_ff <= 8'hFF; cap_ff <= 1'b0; v1_ff <= 1'b0; rdy_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (adv) begin
            phase_ff <= phase_in; bcnt_ff <= bcnt_in; pcnt_ff <= pcnt_in;
            loop_ff <= loop_in; busy_ff <= busy_in; cidx_ff <= cidx_in;
            lresp_ff <= lresp_in; cap_ff <= cap_in; v1_ff <= v1_in; rdy_ff <= rdy_in;
         end
         if (adv && emit) ov_ff <= 1'b1;
         else if (rsp_ready) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && emit) begin
         rsp_tx_valid         <= o_tx;
         rsp_tx_byte          <= o_byte;
         rsp_chip_select_high <= o_cs;
         rsp_done_res         <= o_done;
         rsp_status           <= o_st;
         rsp_high_capacity    <= cap_in;
         rsp_legacy_card      <= v1_in;
         rsp_card_ready       <= rdy_in;
      end
   end
   assign rsp_valid = ov_ff;
endmodule
